>>> src/aes128_pkg.sv
// AES-128 engine package: S-box, round constants, round helpers, mode, register and state codes.
// No dependencies.
package aes128_pkg;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CTR = 2'd2,
		MODE_RSV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_KEY_HI  = 3'd1,
		REG_KEY_LO  = 3'd2,
		REG_IV_HI   = 3'd3,
		REG_IV_LO   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEYX,
		ST_ROUND,
		ST_DONE
	} state_t;

	localparam int NumRounds  = 10;
	localparam int BlockBytes = 16;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return t[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// One encryption round on a 128-bit state, byte 0 in bits 127:120.
	function automatic logic [127:0] enc_round(input logic [127:0] s,
		input logic [127:0] rk, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] o;
		for (int k = 0; k < 16; k++) b[k] = s[127-8*k -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4*c+r] = sbox(b[4*((c+r)%4)+r]);
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int k = 0; k < 16; k++) o[127-8*k -: 8] = t[k];
		return o ^ rk;
	endfunction

	// Next 128-bit round key from the previous one.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] i);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {w3[23:0], w3[31:24]};
		t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])}
			^ {rcon(i), 24'h0};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

>>> src/aes128_keymem.sv
// Round-key store: 11 entries of 128 bits, one write and one registered read port.
// Depends on nothing.
module aes128_keymem (
	input  logic         clk,
	input  logic         we,
	input  logic [3:0]   waddr,
	input  logic [127:0] wdata,
	input  logic [3:0]   raddr,
	output logic [127:0] rdata
);
	logic [127:0] mem [11];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> src/aes128_block_encrypt_modes_unit.sv
// AES-128 ECB / CBC-encrypt / CTR engine top level with key expansion sequencer.
// Depends on aes128_pkg and aes128_keymem.
//
// Usage:
//  - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 mode,
//    1/2 key high/low, 3/4 IV high/low. Write only while idle. A key write forces
//    key expansion before the next block.
//  - Input channel (in_valid/in_ready): data_high, data_low, first, valid_bytes.
//  - Output channel (out_valid/out_ready): out_high, out_low, one per input.
// Timing: one shared round unit does one AES round per cycle. out_valid rises
//  after the input transaction, once the initial key-add step and the 10 rounds are done;
//  after a key change, key expansion comes first, one round key per cycle.
//  One block is in flight; in_ready is low from accept until its result has
//  been taken, so a new block is not accepted before the last one is out.
//  CBC and CTR chaining depend on the prior block's end.
// Reset: mode, key, IV, chaining value cleared, keys marked stale.
// Stall: the result holds in the output register until out_ready.
module aes128_block_encrypt_modes_unit
	import aes128_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [63:0]  data_high,
	input  logic [63:0]  data_low,
	input  logic         first,
	input  logic [4:0]   valid_bytes,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  out_high,
	output logic [63:0]  out_low
);
	state_t       state_q, state_d;
	mode_t        mode_q;
	logic [127:0] key_q, iv_q, chain_q, blk_q, data_q, kexp_q, res_q;
	logic         keys_ok_q;
	logic [3:0]   cnt_q;
	logic [4:0]   len_q;
	logic         rd_wait_q;
	logic [127:0] rk;
	logic         km_we;
	logic [3:0]   km_waddr, km_raddr;
	logic [127:0] km_wdata, nk, rnd;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign out_high  = res_q[127:64];
	assign out_low   = res_q[63:0];

	aes128_keymem u_keymem (
		.clk(clk), .we(km_we), .waddr(km_waddr), .wdata(km_wdata),
		.raddr(km_raddr), .rdata(rk)
	);

	// round key 0 is stored at accept when the keys are stale
	assign nk       = next_key(kexp_q, cnt_q);
	assign km_we    = (state_q == ST_KEYX) || (state_q == ST_IDLE && in_valid && !keys_ok_q);
	assign km_waddr = (state_q == ST_KEYX) ? cnt_q + 4'd1 : 4'd0;
	assign km_wdata = (state_q == ST_KEYX) ? nk : key_q;
	assign rnd      = enc_round(blk_q, rk, cnt_q == 4'(NumRounds));

	// read address leads the round counter by one
	always_comb begin
		if (state_q == ST_ROUND) km_raddr = cnt_q + 4'd1;
		else km_raddr = 4'd0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = keys_ok_q ? ST_ROUND : ST_KEYX;
			ST_KEYX:  if (cnt_q == 4'(NumRounds - 1)) state_d = ST_ROUND;
			ST_ROUND: if (!rd_wait_q && cnt_q == 4'(NumRounds)) state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ECB;
			key_q     <= '0;
			iv_q      <= '0;
			chain_q   <= '0;
			keys_ok_q <= 1'b0;
			cnt_q     <= '0;
			rd_wait_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:   mode_q <= mode_t'(cfg_data[1:0]);
					REG_KEY_HI: begin key_q[127:64] <= cfg_data; keys_ok_q <= 1'b0; end
					REG_KEY_LO: begin key_q[63:0] <= cfg_data; keys_ok_q <= 1'b0; end
					REG_IV_HI:  iv_q[127:64] <= cfg_data;
					REG_IV_LO:  iv_q[63:0] <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: if (in_valid) begin
					cnt_q     <= '0;
					rd_wait_q <= 1'b1;
					if (first) chain_q <= iv_q;
				end
				ST_KEYX: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(NumRounds - 1)) begin
						keys_ok_q <= 1'b1;
						cnt_q     <= '0;
						rd_wait_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					// key-add cycle at count 0, rounds at counts 1 to 10
					rd_wait_q <= 1'b0;
					cnt_q     <= cnt_q + 4'd1;
					if (!rd_wait_q && cnt_q == 4'(NumRounds)) begin
						if (mode_q == MODE_CBC) chain_q <= rnd;
						if (mode_q == MODE_CTR) chain_q[31:0] <= chain_q[31:0] + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			data_q <= {data_high, data_low};
			len_q  <= valid_bytes;
			kexp_q <= key_q;
		end
		if (state_q == ST_KEYX) kexp_q <= nk;
		if (state_q == ST_ROUND) begin
			if (rd_wait_q) begin
				// rk holds round key 0 here
				unique case (mode_q)
					MODE_CBC: blk_q <= chain_q ^ data_q ^ rk;
					MODE_CTR: blk_q <= chain_q ^ rk;
					default:  blk_q <= data_q ^ rk;
				endcase
			end else begin
				blk_q <= rnd;
				if (cnt_q == 4'(NumRounds)) begin
					if (mode_q == MODE_CTR) begin
						for (int k = 0; k < BlockBytes; k++)
							res_q[127-8*k -: 8] <= (5'(k) < len_q)
								? (rnd[127-8*k -: 8] ^ data_q[127-8*k -: 8]) : 8'h00;
					end else begin
						res_q <= rnd;
					end
				end
			end
		end
	end
endmodule

>>> verif/aes128_modes_checker.sv
// Checker for the AES-128 ECB/CBC/CTR engine: watches config, input and output channels,
// predicts each result block and compares it. Depends on aes128_pkg (mode and register codes).
module aes128_modes_checker
	import aes128_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	input  logic        first,
	input  logic [4:0]  valid_bytes,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_high,
	input  logic [63:0] out_low,
	output int          fail_count,
	output int          pending_blocks
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam byte unsigned SBOX_TAB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};
	localparam byte unsigned RCON_TAB [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	mode_t        cur_mode;
	logic [127:0] key_reg, iv_reg, chain_blk;
	logic [127:0] sched [11];
	bit           sched_valid;
	logic [127:0] expected_blocks [$];

	function automatic logic [7:0] gf_dbl(logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic build_schedule();
		logic [31:0] w [44];
		logic [31:0] t;
		for (int i = 0; i < 4; i++) w[i] = key_reg[127-32*i -: 32];
		for (int i = 0; i < 10; i++) begin
			t = {w[4*i+3][23:0], w[4*i+3][31:24]};
			t = {SBOX_TAB[t[31:24]], SBOX_TAB[t[23:16]], SBOX_TAB[t[15:8]], SBOX_TAB[t[7:0]]};
			t ^= {RCON_TAB[i], 24'h0};
			w[4*i+4] = w[4*i] ^ t;
			w[4*i+5] = w[4*i+1] ^ w[4*i+4];
			w[4*i+6] = w[4*i+2] ^ w[4*i+5];
			w[4*i+7] = w[4*i+3] ^ w[4*i+6];
		end
		for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		sched_valid = 1;
	endtask

	function automatic logic [127:0] cipher(logic [127:0] pt);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] v;
		v = pt ^ sched[0];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int k = 0; k < 16; k++) s[k] = v[127-8*k -: 8];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) t[4*c+r] = SBOX_TAB[s[4*((c+r)%4)+r]];
			if (rnd != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
					t[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
					t[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
					t[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
				end
			end
			for (int k = 0; k < 16; k++) v[127-8*k -: 8] = t[k];
			v ^= sched[rnd];
		end
		return v;
	endfunction

	task automatic predict_block(logic [127:0] data, logic ld_iv, logic [4:0] nbytes);
		logic [127:0] ks, res;
		int n;
		if (!sched_valid) build_schedule();
		if (ld_iv) chain_blk = iv_reg;
		case (cur_mode)
			MODE_CBC: begin
				res = cipher(chain_blk ^ data);
				chain_blk = res;
			end
			MODE_CTR: begin
				n = (nbytes > 16) ? 16 : nbytes;
				ks = cipher(chain_blk);
				for (int k = 0; k < 16; k++)
					res[127-8*k -: 8] = (k < n) ? (ks[127-8*k -: 8] ^ data[127-8*k -: 8]) : 8'h00;
				chain_blk[31:0] = chain_blk[31:0] + 32'd1;
			end
			default: res = cipher(data);
		endcase
		expected_blocks.push_back(res);
	endtask

	assign pending_blocks = expected_blocks.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] exp_blk;
		if (!arst_n) begin
			cur_mode = MODE_ECB;
			key_reg = '0;
			iv_reg = '0;
			chain_blk = '0;
			sched_valid = 0;
			expected_blocks.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:   cur_mode = mode_t'(cfg_data[1:0]);
					REG_KEY_HI: begin key_reg[127:64] = cfg_data; sched_valid = 0; end
					REG_KEY_LO: begin key_reg[63:0] = cfg_data; sched_valid = 0; end
					REG_IV_HI:  iv_reg[127:64] = cfg_data;
					REG_IV_LO:  iv_reg[63:0] = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: unexpected result %h_%h", $time, out_high, out_low);
					fail_count++;
				end else begin
					exp_blk = expected_blocks.pop_front();
					if (out_high !== exp_blk[127:64]) begin
						$display("%0t: out_high expected %h actual %h", $time, exp_blk[127:64],
							out_high);
						fail_count++;
					end
					if (out_low !== exp_blk[63:0]) begin
						$display("%0t: out_low expected %h actual %h", $time, exp_blk[63:0],
							out_low);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_block({data_high, data_low}, first, valid_bytes);
		end
	end
endmodule

>>> verif/tb_top.sv
// Top of the AES-128 mode engine testbench: clock, reset, stimulus and verdict.
// Depends on aes128_pkg, aes128_block_encrypt_modes_unit and aes128_modes_checker.
module tb_top
	import aes128_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid, in_ready;
	logic [63:0] data_high, data_low;
	logic        first;
	logic [4:0]  valid_bytes;
	logic        out_valid, out_ready;
	logic [63:0] out_high, out_low;
	int          fail_count, pending_blocks;
	bit          stim_done;

	aes128_block_encrypt_modes_unit u_dut (.*);
	aes128_modes_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stall per transaction, sometimes long runs with none.
	initial begin
		int gap;
		bit eager;
		out_ready = 0;
		eager = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 99) == 0) eager = ~eager;
			gap = eager ? 0 : $urandom_range(0, 12);
			@(negedge clk);
			out_ready = 0;
			repeat (gap) @(negedge clk);
			out_ready = 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic write_bad_index();
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = 3'($urandom_range(5, 7));
		cfg_data = {$urandom, $urandom};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic ld, logic [4:0] nb,
		int gap);
		@(negedge clk);
		repeat (gap) @(negedge clk);
		in_valid = 1;
		data_high = hi;
		data_low = lo;
		first = ld;
		valid_bytes = nb;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (pending_blocks != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int gap;
		logic [63:0] ivl;
		mode_t m;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; data_high = '0; data_low = '0; first = 0; valid_bytes = 5'd16;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// all-zero key, chain never loaded, ECB then CTR from zero counter
		send_block('0, '0, 1'b0, 5'd16, 0);
		drain();
		write_reg(REG_MODE, 64'(MODE_CTR));
		send_block('1, '1, 1'b0, 5'd16, 0);
		drain();
		// FIPS-197 example key, then extremes of each mode
		write_reg(REG_KEY_HI, 64'h0001020304050607);
		write_reg(REG_KEY_LO, 64'h08090a0b0c0d0e0f);
		write_reg(REG_IV_HI, 64'hffffffffffffffff);
		write_reg(REG_IV_LO, 64'hfffffffffffffffe);
		write_reg(REG_MODE, 64'(MODE_ECB));
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 5'd16, 0);
		send_block('1, '1, 1'b0, 5'd1, 2);
		drain();
		write_reg(REG_MODE, 64'(MODE_CBC));
		send_block('0, '0, 1'b1, 5'd16, 0);
		send_block('1, '1, 1'b0, 5'd3, 0);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 5'd16, 1);
		drain();
		write_reg(REG_MODE, 64'(MODE_CTR));
		// counter wrap, then short, zero and over-long lengths
		send_block('1, '1, 1'b1, 5'd16, 0);
		send_block('1, '1, 1'b0, 5'd16, 0);
		send_block('1, '1, 1'b0, 5'd1, 0);
		send_block('1, '1, 1'b0, 5'd15, 0);
		send_block('1, '1, 1'b0, 5'd0, 0);
		send_block('1, '1, 1'b0, 5'd17, 0);
		send_block('1, '1, 1'b0, 5'd31, 0);
		drain();
		write_reg(REG_MODE, 64'(MODE_RSV));
		write_bad_index();
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 5'd16, 0);
		drain();

		// random phases: new settings, then a stream of messages
		for (int phase = 0; phase < 70; phase++) begin
			if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_HI, rand64());
			if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_LO, rand64());
			write_reg(REG_IV_HI, rand64());
			ivl = rand64();
			if ($urandom_range(0, 3) == 0) ivl[31:0] = 32'hffffffff - $urandom_range(0, 5);
			write_reg(REG_IV_LO, ivl);
			m = mode_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
			write_reg(REG_MODE, 64'(m));
			if ($urandom_range(0, 9) == 0) write_bad_index();
			for (int i = 0; i < 25; i++) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				send_block(rand64(), rand64(),
					(i == 0) ? 1'b1 : ($urandom_range(0, 9) == 0),
					(m == MODE_CTR && $urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
						: 5'd16,
					gap);
			end
			drain();
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> files.f
src/aes128_pkg.sv
src/aes128_keymem.sv
src/aes128_block_encrypt_modes_unit.sv
verif/aes128_modes_checker.sv
verif/tb_top.sv
